// File: hdl/btcs_pkg.sv
// Shared types and constants for the block transfer command sequencer.
// Holds the word layouts of both channels, the state and result codes and the
// command numbers. Depends on nothing.
package btcs_pkg;

  localparam int unsigned MAX_MULTI_BLOCKS  = 65535;
  localparam int unsigned MAX_SINGLE_BLOCKS = 1;

  localparam int unsigned CHUNK_LIMIT_W = 11;
  localparam int unsigned CFG_DATA_W    = 11;
  localparam int unsigned COUNT_W       = 16;

  localparam logic [CHUNK_LIMIT_W-1:0] CHUNK_LIMIT_RESET  = 11'd256;
  localparam logic                     PRESET_ENA_RESET   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_CHUNK_LIMIT  = 1'b0,
    REG_PRESET_ENA   = 1'b1
  } reg_index_t;

  // Card command numbers.
  localparam logic [5:0] CMD_STOP        = 6'd12;
  localparam logic [5:0] CMD_READ_SINGLE = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI  = 6'd18;
  localparam logic [5:0] CMD_SET_COUNT   = 6'd23;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] CMD_WRITE_MULTI = 6'd25;

  localparam logic [31:0] RELIABLE_BIT = 32'h8000_0000;

  typedef enum logic [0:0] {
    OP_REQUEST  = 1'b0,
    OP_RESPONSE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_ISSUE    = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_BUSY     = 3'd2,
    KIND_FAILED   = 3'd3,
    KIND_IGNORED  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PRESET = 2'd1,
    PH_DATA   = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic read;
    logic reliable;
    logic preset;
  } req_flags_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] first_lba;
    logic [31:0] num_sectors;
    logic        is_read;
    logic        rel_write;
    logic        card_ready;
    logic        cmd_ok;
  } in_word_t;

  typedef struct packed {
    kind_t              kind;
    logic [5:0]         cmd_num;
    logic [31:0]        cmd_arg;
    logic [COUNT_W-1:0] block_count;
    logic               data_read;
    logic               busy_response;
    logic               last;
  } out_word_t;

endpackage

// File: hdl/block_transfer_command_sequencer.sv
// Top level of the block transfer command sequencer.
// Holds the configuration registers and the input and output word registers
// around btcs_core. Depends on btcs_pkg and btcs_core.
//
// Usage: a word on the input channel is either a block request or the
// response to the last command issued. Every input word yields exactly one
// result word: a command to issue, finished, busy, command failed or ignored.
// After a command word the sender returns the card response as the next
// response word; a request that arrives while a transfer runs is ignored.
// An accepted word waits in the input register until the step moves its result
// into the output register, which offers it on the output channel. Throughput
// is one word per cycle while the receiver does not stall, set by the single
// registered step between the input and output registers. When the receiver
// stalls the result stays in the output register, and the input register still
// takes one more word; only then does in_ready drop. Reset is synchronous: both
// word registers empty, the sequencer idles, and chunk_limit and
// count_preset_enable return to 256 and 1. Configuration is written through
// cfg_we, cfg_index and cfg_data by users while idle, unenforced by the block.
module block_transfer_command_sequencer #(
  parameter int unsigned MAX_MULTI_BLOCKS = btcs_pkg::MAX_MULTI_BLOCKS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  btcs_pkg::in_word_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output btcs_pkg::out_word_t               out_item,
  input  logic                              cfg_we,
  input  btcs_pkg::reg_index_t              cfg_index,
  input  logic [btcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [btcs_pkg::CHUNK_LIMIT_W-1:0] chunk_limit;
  logic                               count_preset_enable;

  logic                in_full;
  btcs_pkg::in_word_t  in_q;
  logic                out_full;
  btcs_pkg::out_word_t out_q;
  btcs_pkg::out_word_t result;
  logic                step;

  assign step      = in_full && (!out_full || out_ready);
  assign in_ready  = !in_full || step;
  assign out_valid = out_full;
  assign out_item  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_limit         <= btcs_pkg::CHUNK_LIMIT_RESET;
      count_preset_enable <= btcs_pkg::PRESET_ENA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        btcs_pkg::REG_CHUNK_LIMIT: chunk_limit <= cfg_data[btcs_pkg::CHUNK_LIMIT_W-1:0];
        btcs_pkg::REG_PRESET_ENA:  count_preset_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (step) begin
        in_full <= 1'b0;
      end
      out_full <= step || (out_full && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
    if (step) begin
      out_q <= result;
    end
  end

  btcs_core #(
    .MAX_MULTI_BLOCKS(MAX_MULTI_BLOCKS)
  ) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .step                (step),
    .item                (in_q),
    .chunk_limit         (chunk_limit),
    .count_preset_enable (count_preset_enable),
    .result              (result)
  );

endmodule

// File: hdl/btcs_core.sv
// Sequencer state and the single-pass step logic for one input word.
// Turns a request or a command response into one result word.
// Depends on btcs_pkg.
module btcs_core #(
  parameter int unsigned MAX_MULTI_BLOCKS = btcs_pkg::MAX_MULTI_BLOCKS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   step,
  input  btcs_pkg::in_word_t                     item,
  input  logic [btcs_pkg::CHUNK_LIMIT_W-1:0]     chunk_limit,
  input  logic                                   count_preset_enable,
  output btcs_pkg::out_word_t                    result
);

  localparam int unsigned CW = btcs_pkg::COUNT_W;
  localparam logic [CW-1:0] MaxMulti  = CW'(MAX_MULTI_BLOCKS);
  localparam logic [CW-1:0] MaxSingle = CW'(btcs_pkg::MAX_SINGLE_BLOCKS);

  btcs_pkg::phase_t     phase, phase_next;
  logic [31:0]          sectors_left, sectors_left_next;
  logic [31:0]          next_sector, next_sector_next;
  logic [CW-1:0]        chunk_size, chunk_size_next;
  logic [CW-1:0]        chunk_cap, chunk_cap_next;
  btcs_pkg::req_flags_t request_flags, request_flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= btcs_pkg::PH_IDLE;
      sectors_left  <= '0;
      next_sector   <= '0;
      chunk_size    <= '0;
      chunk_cap     <= '0;
      request_flags <= '0;
    end else if (step) begin
      phase         <= phase_next;
      sectors_left  <= sectors_left_next;
      next_sector   <= next_sector_next;
      chunk_size    <= chunk_size_next;
      chunk_cap     <= chunk_cap_next;
      request_flags <= request_flags_next;
    end
  end

  always_comb begin
    logic [btcs_pkg::CHUNK_LIMIT_W-1:0] lim;
    logic [CW-1:0]        lim_ext;
    logic [CW-1:0]        new_cap;
    btcs_pkg::req_flags_t new_flags;
    logic [31:0]          adv_left;
    logic [31:0]          adv_next;
    logic [31:0]          sc_left;
    logic [CW-1:0]        sc_cap;
    btcs_pkg::req_flags_t sc_flags;
    logic [31:0]          sc_next;
    logic [CW-1:0]        sc_chunk;
    logic                 sc_preset;
    btcs_pkg::out_word_t  data_res;
    btcs_pkg::out_word_t  preset_res;
    btcs_pkg::out_word_t  chunk_res;
    btcs_pkg::out_word_t  end_res;
    btcs_pkg::out_word_t  ign_res;
    btcs_pkg::phase_t     chunk_phase;

    // New request: a zero limit acts as one sector.
    lim     = (chunk_limit == '0) ? btcs_pkg::CHUNK_LIMIT_W'(1) : chunk_limit;
    lim_ext = CW'(lim);
    if (item.num_sectors > 32'd1) begin
      new_cap = (lim_ext < MaxMulti) ? lim_ext : MaxMulti;
    end else begin
      new_cap = (lim_ext < MaxSingle) ? lim_ext : MaxSingle;
    end
    new_flags.read     = item.is_read;
    new_flags.reliable = item.rel_write;
    new_flags.preset   = count_preset_enable &&
                         ((item.num_sectors > 32'(lim >> 2)) || item.rel_write);

    // Move past the chunk that just finished.
    adv_left = sectors_left - 32'(chunk_size);
    adv_next = next_sector + 32'(chunk_size);

    if (item.opcode == btcs_pkg::OP_REQUEST) begin
      sc_left  = item.num_sectors;
      sc_cap   = new_cap;
      sc_flags = new_flags;
      sc_next  = item.first_lba;
    end else begin
      sc_left  = adv_left;
      sc_cap   = chunk_cap;
      sc_flags = request_flags;
      sc_next  = adv_next;
    end

    // Start of a chunk: either the count preset or the data command itself.
    sc_chunk  = (sc_left > 32'(sc_cap)) ? sc_cap : sc_left[CW-1:0];
    sc_preset = (sc_chunk > CW'(1)) && sc_flags.preset;

    ign_res      = '0;
    ign_res.kind = btcs_pkg::KIND_IGNORED;
    end_res      = '0;
    end_res.last = 1'b1;

    preset_res           = '0;
    preset_res.kind      = btcs_pkg::KIND_ISSUE;
    preset_res.cmd_num   = btcs_pkg::CMD_SET_COUNT;
    preset_res.cmd_arg   = 32'(sc_chunk) |
                           (sc_flags.reliable ? btcs_pkg::RELIABLE_BIT : 32'd0);

    chunk_res             = '0;
    chunk_res.kind        = btcs_pkg::KIND_ISSUE;
    chunk_res.cmd_arg     = sc_next;
    chunk_res.block_count = sc_chunk;
    chunk_res.data_read   = sc_flags.read;
    if (sc_chunk == CW'(1)) begin
      chunk_res.cmd_num = sc_flags.read ? btcs_pkg::CMD_READ_SINGLE
                                        : btcs_pkg::CMD_WRITE_SINGLE;
    end else begin
      chunk_res.cmd_num = sc_flags.read ? btcs_pkg::CMD_READ_MULTI
                                        : btcs_pkg::CMD_WRITE_MULTI;
    end
    if (sc_preset) begin
      chunk_res   = preset_res;
      chunk_phase = btcs_pkg::PH_PRESET;
    end else begin
      chunk_phase = btcs_pkg::PH_DATA;
    end

    // Data command for the chunk already held in state.
    data_res             = '0;
    data_res.kind        = btcs_pkg::KIND_ISSUE;
    data_res.cmd_arg     = next_sector;
    data_res.block_count = chunk_size;
    data_res.data_read   = request_flags.read;
    if (chunk_size == CW'(1)) begin
      data_res.cmd_num = request_flags.read ? btcs_pkg::CMD_READ_SINGLE
                                            : btcs_pkg::CMD_WRITE_SINGLE;
    end else begin
      data_res.cmd_num = request_flags.read ? btcs_pkg::CMD_READ_MULTI
                                            : btcs_pkg::CMD_WRITE_MULTI;
    end

    phase_next         = phase;
    sectors_left_next  = sectors_left;
    next_sector_next   = next_sector;
    chunk_size_next    = chunk_size;
    chunk_cap_next     = chunk_cap;
    request_flags_next = request_flags;
    result             = ign_res;

    if (item.opcode == btcs_pkg::OP_REQUEST) begin
      if (phase != btcs_pkg::PH_IDLE) begin
        result = ign_res;
      end else if (item.num_sectors == 32'd0) begin
        result      = end_res;
        result.kind = btcs_pkg::KIND_DONE;
      end else if (!item.card_ready) begin
        result      = end_res;
        result.kind = btcs_pkg::KIND_BUSY;
      end else begin
        chunk_cap_next     = new_cap;
        request_flags_next = new_flags;
        sectors_left_next  = item.num_sectors;
        next_sector_next   = item.first_lba;
        chunk_size_next    = sc_chunk;
        phase_next         = chunk_phase;
        result             = chunk_res;
      end
    end else begin
      case (phase)
        btcs_pkg::PH_PRESET: begin
          if (!item.cmd_ok) begin
            phase_next  = btcs_pkg::PH_IDLE;
            result      = end_res;
            result.kind = btcs_pkg::KIND_FAILED;
          end else begin
            phase_next = btcs_pkg::PH_DATA;
            result     = data_res;
          end
        end
        btcs_pkg::PH_DATA, btcs_pkg::PH_STOP: begin
          if (phase == btcs_pkg::PH_DATA && !item.cmd_ok) begin
            phase_next  = btcs_pkg::PH_IDLE;
            result      = end_res;
            result.kind = btcs_pkg::KIND_FAILED;
          end else if (phase == btcs_pkg::PH_DATA && chunk_size > CW'(1) &&
                       !request_flags.preset) begin
            phase_next           = btcs_pkg::PH_STOP;
            result               = '0;
            result.kind          = btcs_pkg::KIND_ISSUE;
            result.cmd_num       = btcs_pkg::CMD_STOP;
            result.busy_response = 1'b1;
          end else begin
            // A failed stop command is passed over and the transfer goes on.
            sectors_left_next = adv_left;
            next_sector_next  = adv_next;
            if (adv_left == 32'd0) begin
              phase_next  = btcs_pkg::PH_IDLE;
              result      = end_res;
              result.kind = btcs_pkg::KIND_DONE;
            end else begin
              chunk_size_next = sc_chunk;
              phase_next      = chunk_phase;
              result          = chunk_res;
            end
          end
        end
        default: begin
          result = ign_res;
        end
      endcase
    end
  end

endmodule

// File: sim/btcs_checker.sv
// Checker for the block transfer command sequencer: watches both channels and
// the register port, predicts every result word and compares it field by field.
// Depends on btcs_pkg only.
`timescale 1ns / 100ps
module btcs_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  btcs_pkg::in_word_t              in_item,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  btcs_pkg::out_word_t             out_item,
  input  logic                            cfg_we,
  input  btcs_pkg::reg_index_t            cfg_index,
  input  logic [btcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            xfer_open,
  output int                              fail_count,
  output int                              results_due,
  output int                              words_in,
  output int                              results_seen,
  output int                              xfers_done
);

  typedef struct packed {
    btcs_pkg::phase_t     ph;
    logic [31:0]          left;
    logic [31:0]          next_lba;
    logic [15:0]          chunk;
    logic [15:0]          cap;
    btcs_pkg::req_flags_t fl;
  } seq_state_t;

  typedef struct packed {
    seq_state_t          st;
    btcs_pkg::out_word_t res;
  } step_t;

  seq_state_t                          state;
  logic [btcs_pkg::CHUNK_LIMIT_W-1:0]  limit_reg;
  logic                                preset_reg;
  btcs_pkg::out_word_t                 due_q[$];
  int                                  mismatches;
  int                                  n_in;
  int                                  n_res;
  int                                  n_done;
  step_t                               look;

  function automatic step_t end_xfer(step_t r, btcs_pkg::kind_t k);
    r.st.ph = btcs_pkg::PH_IDLE;
    r.res = '0;
    r.res.kind = k;
    r.res.last = 1'b1;
    return r;
  endfunction

  function automatic step_t issue_data(step_t r);
    logic rd;
    rd = r.st.fl.read;
    r.st.ph = btcs_pkg::PH_DATA;
    r.res = '0;
    r.res.kind = btcs_pkg::KIND_ISSUE;
    if (r.st.chunk == 16'd1) begin
      r.res.cmd_num = rd ? btcs_pkg::CMD_READ_SINGLE : btcs_pkg::CMD_WRITE_SINGLE;
    end else begin
      r.res.cmd_num = rd ? btcs_pkg::CMD_READ_MULTI : btcs_pkg::CMD_WRITE_MULTI;
    end
    r.res.cmd_arg = r.st.next_lba;
    r.res.block_count = r.st.chunk;
    r.res.data_read = rd;
    return r;
  endfunction

  function automatic step_t start_chunk(step_t r);
    r.st.chunk = (r.st.left > {16'd0, r.st.cap}) ? r.st.cap : r.st.left[15:0];
    if (r.st.chunk > 16'd1 && r.st.fl.preset) begin
      r.st.ph = btcs_pkg::PH_PRESET;
      r.res = '0;
      r.res.kind = btcs_pkg::KIND_ISSUE;
      r.res.cmd_num = btcs_pkg::CMD_SET_COUNT;
      r.res.cmd_arg = {16'd0, r.st.chunk} |
                      (r.st.fl.reliable ? btcs_pkg::RELIABLE_BIT : 32'd0);
    end else begin
      r = issue_data(r);
    end
    return r;
  endfunction

  function automatic step_t advance(step_t r);
    r.st.left = r.st.left - {16'd0, r.st.chunk};
    r.st.next_lba = r.st.next_lba + {16'd0, r.st.chunk};
    if (r.st.left == 32'd0) begin
      r = end_xfer(r, btcs_pkg::KIND_DONE);
    end else begin
      r = start_chunk(r);
    end
    return r;
  endfunction

  // Next state and result word for one accepted input word.
  function automatic step_t sequence_word(seq_state_t s,
                                          logic [btcs_pkg::CHUNK_LIMIT_W-1:0] lim_reg,
                                          logic pe, btcs_pkg::in_word_t w);
    step_t       r;
    logic [31:0] lim;
    logic [31:0] cap;
    r.st = s;
    r.res = '0;
    r.res.kind = btcs_pkg::KIND_IGNORED;
    if (w.opcode == btcs_pkg::OP_REQUEST) begin
      if (s.ph == btcs_pkg::PH_IDLE) begin
        if (w.num_sectors == 32'd0) begin
          r = end_xfer(r, btcs_pkg::KIND_DONE);
        end else if (!w.card_ready) begin
          r = end_xfer(r, btcs_pkg::KIND_BUSY);
        end else begin
          lim = (lim_reg == '0) ? 32'd1 : 32'(lim_reg);
          cap = (w.num_sectors > 32'd1) ? 32'(btcs_pkg::MAX_MULTI_BLOCKS)
                                        : 32'(btcs_pkg::MAX_SINGLE_BLOCKS);
          if (cap > lim) cap = lim;
          r.st.cap = cap[15:0];
          r.st.fl.read = w.is_read;
          r.st.fl.reliable = w.rel_write;
          r.st.fl.preset = pe && ((w.num_sectors > lim / 4) || w.rel_write);
          r.st.left = w.num_sectors;
          r.st.next_lba = w.first_lba;
          r = start_chunk(r);
        end
      end
    end else begin
      case (s.ph)
        btcs_pkg::PH_PRESET: begin
          r = w.cmd_ok ? issue_data(r) : end_xfer(r, btcs_pkg::KIND_FAILED);
        end
        btcs_pkg::PH_DATA: begin
          if (!w.cmd_ok) begin
            r = end_xfer(r, btcs_pkg::KIND_FAILED);
          end else if (s.chunk > 16'd1 && !s.fl.preset) begin
            r.st.ph = btcs_pkg::PH_STOP;
            r.res = '0;
            r.res.kind = btcs_pkg::KIND_ISSUE;
            r.res.cmd_num = btcs_pkg::CMD_STOP;
            r.res.busy_response = 1'b1;
          end else begin
            r = advance(r);
          end
        end
        // A failed stop command is not an error; the transfer moves on.
        btcs_pkg::PH_STOP: begin
          r = advance(r);
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // Lookahead: whether a transfer is open once the word now offered is taken.
  always_comb begin
    look = sequence_word(state, limit_reg, preset_reg, in_item);
  end
  assign xfer_open = (look.st.ph != btcs_pkg::PH_IDLE);

  always @(posedge clk) begin : track
    step_t               nxt;
    btcs_pkg::out_word_t want;
    if (rst) begin
      state <= '0;
      limit_reg <= btcs_pkg::CHUNK_LIMIT_RESET;
      preset_reg <= btcs_pkg::PRESET_ENA_RESET;
      due_q.delete();
      mismatches = 0;
      n_in = 0;
      n_res = 0;
      n_done = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_res++;
        if (out_item.last && out_item.kind == btcs_pkg::KIND_DONE) n_done++;
        if (due_q.size() == 0) begin
          $error("unexpected result word: kind %0d", out_item.kind);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_item.kind));
          check_field("cmd_num", 32'(want.cmd_num), 32'(out_item.cmd_num));
          check_field("cmd_arg", want.cmd_arg, out_item.cmd_arg);
          check_field("block_count", 32'(want.block_count), 32'(out_item.block_count));
          check_field("data_read", 32'(want.data_read), 32'(out_item.data_read));
          check_field("busy_response", 32'(want.busy_response),
                      32'(out_item.busy_response));
          check_field("last", 32'(want.last), 32'(out_item.last));
        end
      end
      if (in_valid && in_ready) begin
        nxt = sequence_word(state, limit_reg, preset_reg, in_item);
        state <= nxt.st;
        due_q.push_back(nxt.res);
        n_in++;
      end
      if (cfg_we) begin
        case (cfg_index)
          btcs_pkg::REG_CHUNK_LIMIT: limit_reg <= cfg_data[btcs_pkg::CHUNK_LIMIT_W-1:0];
          btcs_pkg::REG_PRESET_ENA:  preset_reg <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
    results_due <= due_q.size();
    fail_count <= mismatches;
    words_in <= n_in;
    results_seen <= n_res;
    xfers_done <= n_done;
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the block transfer command sequencer: clock, reset,
// register writes, request and response stimulus, output stalls and verdict.
// Depends on btcs_pkg, block_transfer_command_sequencer and btcs_checker.
`timescale 1ns / 100ps
module tb_top;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_WORDS = 78;
  localparam int NUM_PHASES  = 10;
  localparam int unsigned LIMIT_W = btcs_pkg::CHUNK_LIMIT_W;
  localparam int unsigned DATA_W  = btcs_pkg::CFG_DATA_W;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  btcs_pkg::in_word_t   in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  btcs_pkg::out_word_t  out_item;
  logic                 cfg_we = 1'b0;
  btcs_pkg::reg_index_t cfg_index = btcs_pkg::REG_CHUNK_LIMIT;
  logic [DATA_W-1:0]    cfg_data = '0;

  logic xfer_open;
  int   fail_count;
  int   results_due;
  int   words_in;
  int   results_seen;
  int   xfers_done;

  // Stimulus-side view of the sequencer after the last accepted word.
  logic               open_xfer = 1'b0;
  logic [LIMIT_W-1:0] cur_limit = btcs_pkg::CHUNK_LIMIT_RESET;
  int                 useful = 0;
  logic               hold_req = 1'b0;
  logic               steady = 1'b0;

  block_transfer_command_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  btcs_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .xfer_open    (xfer_open),
    .fail_count   (fail_count),
    .results_due  (results_due),
    .words_in     (words_in),
    .results_seen (results_seen),
    .xfers_done   (xfers_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic btcs_pkg::in_word_t make_request(logic [31:0] lba, logic [31:0] n,
                                                      logic rd, logic rel, logic rdy);
    btcs_pkg::in_word_t w;
    w.opcode = btcs_pkg::OP_REQUEST;
    w.first_lba = lba;
    w.num_sectors = n;
    w.is_read = rd;
    w.rel_write = rel;
    w.card_ready = rdy;
    w.cmd_ok = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Request fields in a response word are don't-care, so they carry noise.
  function automatic btcs_pkg::in_word_t make_response(logic ok);
    btcs_pkg::in_word_t w;
    w.opcode = btcs_pkg::OP_RESPONSE;
    w.first_lba = $urandom;
    w.num_sectors = $urandom;
    w.is_read = 1'($urandom_range(0, 1));
    w.rel_write = 1'($urandom_range(0, 1));
    w.card_ready = 1'($urandom_range(0, 1));
    w.cmd_ok = ok;
    return w;
  endfunction

  function automatic logic [31:0] pick_lba();
    if ($urandom_range(0, 3) == 0) return 32'hFFFF_FFFF - $urandom_range(0, 3000);
    return $urandom;
  endfunction

  task automatic send_word(btcs_pkg::in_word_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (!in_ready);
    if ((w.opcode == btcs_pkg::OP_REQUEST) ? !open_xfer : open_xfer) useful++;
    open_xfer = xfer_open;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // Ends any open transfer with a failing response, then waits for all results.
  task automatic quiesce();
    while (open_xfer) send_word(make_response(1'b0));
    drain();
  endtask

  task automatic set_config(logic [LIMIT_W-1:0] limit, logic pe);
    cfg_we <= 1'b1;
    cfg_index <= btcs_pkg::REG_CHUNK_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_index <= btcs_pkg::REG_PRESET_ENA;
    cfg_data <= {{(DATA_W-1){1'b0}}, pe};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_limit = limit;
  endtask

  task automatic random_word();
    btcs_pkg::in_word_t w;
    int unsigned        lim;
    logic [31:0]        n;
    lim = (cur_limit == '0) ? 1 : int'(cur_limit);
    if ($urandom_range(0, 99) < 12) begin
      w = make_response(1'($urandom_range(0, 1)));
      w.opcode = 1'($urandom_range(0, 1));
    end else if (open_xfer) begin
      w = make_response($urandom_range(0, 11) != 0);
    end else begin
      case ($urandom_range(0, 9))
        0:       n = 32'd0;
        1, 2:    n = 32'd1;
        3, 4, 5: n = $urandom_range(2, lim / 2 + 2);
        6, 7:    n = $urandom_range(2, 3 * lim);
        8:       n = lim / 4 + $urandom_range(0, 1);
        default: n = $urandom;
      endcase
      w = make_request(pick_lba(), n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 9) != 0);
    end
    send_word(w);
  endtask

  // Output side: random stalls per word, plus one long hold-off on request.
  initial begin : receiver
    int   stall;
    logic held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = steady ? 0 : $urandom_range(0, 3);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset settings (limit 256, count preset on).
    send_word(make_response(1'b1));
    send_word(make_request(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1, 1'b1));
    send_word(make_request(32'd0, 32'd5, 1'b0, 1'b0, 1'b0));
    send_word(make_request(32'hFFFF_FFFF, 32'd1, 1'b1, 1'b0, 1'b1));
    send_word(make_response(1'b1));
    send_word(make_request(32'd0, 32'd1, 1'b0, 1'b0, 1'b1));
    send_word(make_response(1'b0));
    // Short multi-block write without preset: stop command, whose failure is ignored.
    send_word(make_request(32'd100, 32'd2, 1'b0, 1'b0, 1'b1));
    send_word(make_request(32'd5, 32'd9, 1'b1, 1'b0, 1'b1));
    send_word(make_response(1'b1));
    send_word(make_response(1'b0));
    send_word(make_request(32'd9, 32'd2, 1'b1, 1'b0, 1'b1));
    send_word(make_response(1'b1));
    send_word(make_response(1'b1));
    // Reliable write forces the preset with the top bit set.
    send_word(make_request(32'd7, 32'd3, 1'b0, 1'b1, 1'b1));
    send_word(make_response(1'b1));
    send_word(make_response(1'b1));
    send_word(make_request(32'd50, 32'd300, 1'b1, 1'b0, 1'b1));
    send_word(make_response(1'b0));
    // Largest count, starting just below the top of the sector space so it wraps.
    send_word(make_request(32'hFFFF_FF80, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1));
    send_word(make_response(1'b1));
    send_word(make_response(1'b1));
    send_word(make_response(1'b1));
    send_word(make_response(1'b0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      case (p)
        0:       set_config(11'd1, 1'b1);
        1:       set_config(11'd0, 1'b1);
        2:       set_config(11'd2047, 1'b0);
        3:       set_config(11'd1024, 1'b1);
        4:       set_config(11'd4, 1'b0);
        5:       set_config(11'd3, 1'b1);
        6:       set_config(11'd256, 1'b0);
        default: set_config(11'($urandom_range(1, 1024)), 1'($urandom_range(0, 1)));
      endcase
      // Phase 3 runs without gaps and with one long output hold-off, so the
      // block fills and stalls its input.
      if (p == 3) begin
        steady <= 1'b1;
        hold_req <= 1'b1;
      end else if (p == 4) begin
        steady <= 1'b0;
      end
      useful = 0;
      k = 0;
      while (useful < PHASE_WORDS) begin
        random_word();
        k++;
        if (p == 6 && k == 40) drain();
      end
    end
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input words and %0d checked results, %0d transfers finished ok,",
             words_in, results_seen, xfers_done);
    $display("over %0d register settings with random and zero stalls and one long hold-off.",
             NUM_PHASES + 1);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
